// ===== src/lsbs_pkg.sv =====
// Package with the shared types and constants of the LED strip bit serializer.
package lsbs_pkg;

   localparam int MAX_LEDS = 512;
   localparam int BANK_BYTES = 3 * MAX_LEDS;
   localparam int STORE_DEPTH = 2 * BANK_BYTES;
   localparam int STORE_AW = $clog2(STORE_DEPTH);
   localparam int INDEX_W = 11;
   localparam int COUNT_W = 10;
   localparam int PIXEL_W = COUNT_W + 2;
   localparam int LATCH_MAX = 3 * ((MAX_LEDS + 63) / 64);
   localparam int LATCH_W = $clog2(LATCH_MAX + 1);
   localparam int LED_COUNT_RESET = 320;
   localparam int LATCH_RESET = 3 * ((LED_COUNT_RESET + 63) / 64);
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_SWAP = 2'd2;

   localparam logic CSR_REG_LED_COUNT = 1'b0;

   localparam logic [2:0] BIT_MSB = 3'd7;
   localparam logic [2:0] BIT_LSB = 3'd0;

   typedef struct packed {
      logic [1:0] kind;
      logic [INDEX_W-1:0] byte_address;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic data_bit;
      logic in_latch;
      logic last_of_byte;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic [2:0] bit_position;
      logic in_latch;
      logic last_of_byte;
   } tick_type;

endpackage

// ===== src/led_strip_bit_serializer.sv =====
// Top level of the double-buffered LED strip bit serializer.
// The request channel takes one beat per item: a tick emits one serial bit, a write
// stores a color byte into the back bank, and a swap exchanges front and back banks
// at once. Only ticks give a response beat, carrying the data level, whether the bit
// belongs to the zero latch bytes, and whether it is the last bit of its byte.
// Pixel bytes are shown with the top bit forced high; a frame is the latch followed
// by three bytes per LED, repeated without end.
// Each tick reads the pixel store (two banks in one synchronous RAM) in the cycle it
// is accepted; it then passes from the read stage into the output register, and its
// response beat leaves from there. One item is taken every cycle while the response
// side keeps up, so the sustained rate is one item per cycle, set by the single read
// port of the pixel store.
// When the receiver stalls, the finished beat waits in the output register and one
// more tick may sit in the read stage; after that req_ready drops until a beat leaves.
// The user must write the LED count register through the APB port while the block is idle
// (not enforced). Synchronous reset sets the count to 320, shows bank zero and starts with
// the latch; the pixel store is not cleared and must be written before it is shown.
module led_strip_bit_serializer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lsbs_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lsbs_pkg::rsp_type            rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [lsbs_pkg::PADDR_W-1:0] paddr,
   input  logic [lsbs_pkg::PDATA_W-1:0] pwdata,
   output logic [lsbs_pkg::PDATA_W-1:0] prdata,
   output logic                         pready
);

   logic                          ram_wr_en;
   logic [lsbs_pkg::STORE_AW-1:0] ram_wr_addr;
   logic [7:0]                    ram_wr_data;
   logic                          ram_rd_en;
   logic [lsbs_pkg::STORE_AW-1:0] ram_rd_addr;
   logic [7:0]                    ram_rd_data;
   lsbs_pkg::tick_type            tick;

   assign pready = 1'b1;

   lsbs_ram #(
      .Width(8),
      .Depth(lsbs_pkg::STORE_DEPTH)
   ) u_store (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   lsbs_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .ram_wr_en(ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_en(ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .tick(tick)
   );

   lsbs_out u_out (
      .clock(clock),
      .reset(reset),
      .tick(tick),
      .ram_rd_data(ram_rd_data),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

// ===== src/lsbs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lsbs_ram #(
   parameter int Width = 8,
   parameter int Depth = 256,
   parameter int AddrWidth = $clog2(Depth)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lsbs_ctrl.sv =====
// Frame sequencer: register port, bank select, bit and byte counters, store access.
module lsbs_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  lsbs_pkg::req_type             req_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lsbs_pkg::PADDR_W-1:0]  paddr,
   input  logic [lsbs_pkg::PDATA_W-1:0]  pwdata,
   output logic [lsbs_pkg::PDATA_W-1:0]  prdata,
   output logic                          ram_wr_en,
   output logic [lsbs_pkg::STORE_AW-1:0] ram_wr_addr,
   output logic [7:0]                    ram_wr_data,
   output logic                          ram_rd_en,
   output logic [lsbs_pkg::STORE_AW-1:0] ram_rd_addr,
   output lsbs_pkg::tick_type            tick
);

   logic [lsbs_pkg::COUNT_W-1:0] led_count_ff, led_count_in;
   logic                         front_ff, front_in;
   logic [2:0]                   bit_pos_ff, bit_pos_in;
   logic                         latch_ff, latch_in;
   logic [lsbs_pkg::INDEX_W-1:0] byte_index_ff, byte_index_in;
   logic [lsbs_pkg::LATCH_W-1:0] latch_rem_ff, latch_rem_in;

   logic                         accept;
   logic                         is_tick;
   logic                         last;
   logic [lsbs_pkg::COUNT_W-1:0] eff_leds;
   logic [lsbs_pkg::PIXEL_W-1:0] pixel_bytes;
   logic [lsbs_pkg::COUNT_W:0]   leds_round;
   logic [lsbs_pkg::LATCH_W-1:0] latch_len;
   logic [lsbs_pkg::INDEX_W-1:0] next_index;
   logic [lsbs_pkg::LATCH_W-1:0] rem_dec;
   logic [lsbs_pkg::INDEX_W-1:0] index_mod;
   logic                         csr_write;

   assign accept = req_valid && req_ready;
   assign is_tick = accept && (req_data.kind == lsbs_pkg::KIND_TICK);
   assign last = (bit_pos_ff == lsbs_pkg::BIT_LSB);
   assign csr_write = psel && penable && pwrite
                      && (paddr[lsbs_pkg::PADDR_W-1] == lsbs_pkg::CSR_REG_LED_COUNT);

   always_comb begin
      if (led_count_ff == '0) begin
         eff_leds = lsbs_pkg::COUNT_W'(1);
      end else if (32'(led_count_ff) > lsbs_pkg::MAX_LEDS) begin
         eff_leds = lsbs_pkg::COUNT_W'(lsbs_pkg::MAX_LEDS);
      end else begin
         eff_leds = led_count_ff;
      end
      pixel_bytes = lsbs_pkg::PIXEL_W'(eff_leds) + {1'b0, eff_leds, 1'b0};
      leds_round = (lsbs_pkg::COUNT_W + 1)'(eff_leds) + (lsbs_pkg::COUNT_W + 1)'(63);
      latch_len = lsbs_pkg::LATCH_W'(leds_round >> 6) +
                  lsbs_pkg::LATCH_W'({leds_round >> 6, 1'b0});
   end

   always_comb begin
      if (32'(byte_index_ff) >= lsbs_pkg::BANK_BYTES) begin
         index_mod = lsbs_pkg::INDEX_W'(32'(byte_index_ff) - lsbs_pkg::BANK_BYTES);
      end else begin
         index_mod = byte_index_ff;
      end
   end

   always_comb begin
      ram_wr_en = accept && (req_data.kind == lsbs_pkg::KIND_WRITE)
                  && (32'(req_data.byte_address) < lsbs_pkg::BANK_BYTES);
      ram_wr_addr = lsbs_pkg::STORE_AW'(req_data.byte_address)
                    + (front_ff ? '0 : lsbs_pkg::STORE_AW'(lsbs_pkg::BANK_BYTES));
      ram_wr_data = req_data.byte_value;
      ram_rd_en = is_tick;
      ram_rd_addr = lsbs_pkg::STORE_AW'(index_mod)
                    + (front_ff ? lsbs_pkg::STORE_AW'(lsbs_pkg::BANK_BYTES) : '0);
      tick.valid = is_tick;
      tick.bit_position = bit_pos_ff;
      tick.in_latch = latch_ff;
      tick.last_of_byte = last;
   end

   always_comb begin
      led_count_in = led_count_ff;
      front_in = front_ff;
      bit_pos_in = bit_pos_ff;
      latch_in = latch_ff;
      byte_index_in = byte_index_ff;
      latch_rem_in = latch_rem_ff;
      next_index = byte_index_ff + lsbs_pkg::INDEX_W'(1);
      rem_dec = (latch_rem_ff != '0) ? latch_rem_ff - lsbs_pkg::LATCH_W'(1) : '0;
      if (csr_write) begin
         led_count_in = pwdata[lsbs_pkg::COUNT_W-1:0];
      end
      if (accept && (req_data.kind == lsbs_pkg::KIND_SWAP)) begin
         front_in = !front_ff;
      end
      if (is_tick) begin
         if (last) begin
            bit_pos_in = lsbs_pkg::BIT_MSB;
            if (!latch_ff) begin
               byte_index_in = next_index;
               if (lsbs_pkg::PIXEL_W'(next_index) >= pixel_bytes) begin
                  latch_in = 1'b1;
                  latch_rem_in = latch_len;
               end
            end else begin
               latch_rem_in = rem_dec;
               if (rem_dec == '0) begin
                  latch_in = 1'b0;
                  byte_index_in = '0;
               end
            end
         end else begin
            bit_pos_in = bit_pos_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= lsbs_pkg::COUNT_W'(lsbs_pkg::LED_COUNT_RESET);
         front_ff <= 1'b0;
         bit_pos_ff <= lsbs_pkg::BIT_MSB;
         latch_ff <= 1'b1;
         byte_index_ff <= '0;
         latch_rem_ff <= lsbs_pkg::LATCH_W'(lsbs_pkg::LATCH_RESET);
      end else begin
         led_count_ff <= led_count_in;
         front_ff <= front_in;
         bit_pos_ff <= bit_pos_in;
         latch_ff <= latch_in;
         byte_index_ff <= byte_index_in;
         latch_rem_ff <= latch_rem_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[lsbs_pkg::PADDR_W-1] == lsbs_pkg::CSR_REG_LED_COUNT) begin
         prdata = lsbs_pkg::PDATA_W'(led_count_ff);
      end
   end

endmodule

// ===== src/lsbs_out.sv =====
// Output stage: combines the fetched byte with the bit position and holds the result beat.
module lsbs_out (
   input  logic               clock,
   input  logic               reset,
   input  lsbs_pkg::tick_type tick,
   input  logic [7:0]         ram_rd_data,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lsbs_pkg::rsp_type  rsp_data
);

   logic               s1_valid_ff, s1_valid_in;
   lsbs_pkg::tick_type s1_ff, s1_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lsbs_pkg::rsp_type  rsp_ff, rsp_in;
   logic               s1_move;
   logic [7:0]         shown_byte;

   assign s1_move = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_move;
   assign shown_byte = {1'b1, ram_rd_data[6:0]};

   always_comb begin
      s1_in = s1_ff;
      s1_valid_in = s1_valid_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = s1_valid_ff;
         rsp_in.data_bit = s1_ff.in_latch ? 1'b0 : shown_byte[s1_ff.bit_position];
         rsp_in.in_latch = s1_ff.in_latch;
         rsp_in.last_of_byte = s1_ff.last_of_byte;
         s1_valid_in = 1'b0;
      end
      if (tick.valid) begin
         s1_valid_in = 1'b1;
         s1_in = tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_ff <= s1_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
